// File: sv/fira_pkg.sv
package fira_pkg;

  localparam int IdW        = 10;
  localparam int TotalIdsDef = 1024;
  localparam int FirstIdDef  = 256;

  localparam logic KindAlloc   = 1'b0;
  localparam logic KindRelease = 1'b1;

  typedef struct packed {
    logic valid;
    logic grant;
    logic from_mem;
    logic overflow;
  } rsp_ctrl_t;

endpackage

// File: sv/free_id_ring_allocator_unit.sv
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------
// item in   | start, busy                | kind_i, release_id_i
// result    | result_valid_o (strobe)    | granted_id_o, overflow_o
//
// one beat accepted per cycle when start is high and busy is low
// busy stays low: ring read, pointer update and ring write all take place on the beat's own clock edge
// result strobes in the cycle after its beat, for one cycle only
// after reset the ring is ready at once, unwritten slots read by fill count
// results cannot be stalled by the receiver
module free_id_ring_allocator_unit import fira_pkg::*; #(
  parameter int TotalIds = TotalIdsDef,
  parameter int FirstId  = FirstIdDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic           kind_i,
  input  logic [IdW-1:0] release_id_i,
  output logic           result_valid_o,
  output logic [IdW-1:0] granted_id_o,
  output logic           overflow_o
);

  localparam int PtrW = $clog2(TotalIds);

  logic            accept;
  logic            rd_en, wr_en;
  logic [PtrW-1:0] rd_addr, wr_addr;
  logic [IdW-1:0]  wr_data, rd_data, init_id;
  rsp_ctrl_t       rsp;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  fira_ctrl #(
    .TotalIds (TotalIds),
    .FirstId  (FirstId),
    .PtrW     (PtrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .release_id_i (release_id_i),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rsp_o        (rsp),
    .init_id_o    (init_id)
  );

  fira_ring_mem #(
    .TotalIds (TotalIds),
    .PtrW     (PtrW)
  ) u_ring (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  always_comb begin
    granted_id_o = '0;
    if (rsp.valid && rsp.grant) begin
      granted_id_o = rsp.from_mem ? rd_data : init_id;
    end
  end

  assign result_valid_o = rsp.valid;
  assign overflow_o     = rsp.valid && rsp.overflow;

endmodule

// File: sv/fira_ring_mem.sv
module fira_ring_mem import fira_pkg::*; #(
  parameter int TotalIds = TotalIdsDef,
  parameter int PtrW     = $clog2(TotalIds)
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [PtrW-1:0] rd_addr_i,
  input  logic            wr_en_i,
  input  logic [PtrW-1:0] wr_addr_i,
  input  logic [IdW-1:0]  wr_data_i,
  output logic [IdW-1:0]  rd_data_o
);

  logic [IdW-1:0] mem [TotalIds];
  logic [IdW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/fira_ctrl.sv
module fira_ctrl import fira_pkg::*; #(
  parameter int TotalIds = TotalIdsDef,
  parameter int FirstId  = FirstIdDef,
  parameter int PtrW     = $clog2(TotalIds)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            kind_i,
  input  logic [IdW-1:0]  release_id_i,
  output logic            rd_en_o,
  output logic [PtrW-1:0] rd_addr_o,
  output logic            wr_en_o,
  output logic [PtrW-1:0] wr_addr_o,
  output logic [IdW-1:0]  wr_data_o,
  output rsp_ctrl_t       rsp_o,
  output logic [IdW-1:0]  init_id_o
);

  localparam int CntW = $clog2(TotalIds + 1);
  localparam int WrStart = (TotalIds - (FirstId % TotalIds)) % TotalIds;
  localparam logic [PtrW-1:0] WrStartP = PtrW'(WrStart);
  localparam logic [PtrW-1:0] LastP    = PtrW'(TotalIds - 1);
  localparam logic [PtrW:0]   TotalX   = (PtrW+1)'(TotalIds);
  localparam logic [PtrW:0]   FullX    = (PtrW+1)'(TotalIds - 1);
  localparam logic [CntW-1:0] CntMax   = CntW'(TotalIds);

  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] wr_cnt_q, wr_cnt_d;
  rsp_ctrl_t       rsp_q, rsp_d;
  logic [IdW-1:0]  init_id_q;

  logic [PtrW:0]   held;
  logic [PtrW:0]   rd_dist;
  logic            empty, full, do_alloc, do_write, is_release;
  logic [IdW-1:0]  init_sum;

  always_comb begin
    if (wr_ptr_q >= rd_ptr_q) begin
      held = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
    end else begin
      held = {1'b0, wr_ptr_q} + TotalX - {1'b0, rd_ptr_q};
    end
  end

  // distance of the read slot from the first slot ever written
  always_comb begin
    if (rd_ptr_q >= WrStartP) begin
      rd_dist = {1'b0, rd_ptr_q} - {1'b0, WrStartP};
    end else begin
      rd_dist = {1'b0, rd_ptr_q} + TotalX - {1'b0, WrStartP};
    end
  end

  assign empty      = (rd_ptr_q == wr_ptr_q);
  assign full       = (held >= FullX);
  assign is_release = (kind_i == KindRelease);
  assign do_alloc   = accept_i && !is_release && !empty;
  assign do_write   = accept_i && is_release && (release_id_i != '0) && !full;
  assign init_sum   = IdW'(FirstId) + IdW'(rd_ptr_q);

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    wr_cnt_d = wr_cnt_q;
    if (do_alloc) begin
      rd_ptr_d = (rd_ptr_q == LastP) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_write) begin
      wr_ptr_d = (wr_ptr_q == LastP) ? '0 : wr_ptr_q + 1'b1;
      if (wr_cnt_q != CntMax) begin
        wr_cnt_d = wr_cnt_q + 1'b1;
      end
    end
    rsp_d.valid    = accept_i;
    rsp_d.grant    = do_alloc;
    rsp_d.from_mem = do_alloc && (CntW'(rd_dist) < wr_cnt_q);
    rsp_d.overflow = accept_i && is_release && (release_id_i != '0) && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= WrStartP;
      wr_cnt_q <= '0;
      rsp_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      wr_cnt_q <= wr_cnt_d;
      rsp_q    <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_alloc) begin
      init_id_q <= init_sum;
    end
  end

  assign rd_en_o   = do_alloc;
  assign rd_addr_o = rd_ptr_q;
  assign wr_en_o   = do_write;
  assign wr_addr_o = wr_ptr_q;
  assign wr_data_o = release_id_i;
  assign rsp_o     = rsp_q;
  assign init_id_o = init_id_q;

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> held < FullX)
    else $error("write into a full ring");

  a_held_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held <= FullX)
    else $error("ring holds more than its capacity");

  a_one_result_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> rsp_q.valid)
    else $error("accepted beat without a result");

  a_overflow_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.overflow |-> rsp_q.valid && !rsp_q.grant)
    else $error("overflow flagged on a grant");

  a_pop_leaves_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |=> rd_ptr_q != $past(rd_ptr_q))
    else $error("read pointer stuck after pop");

endmodule
